// ===== src/cfsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsb_pkg
// Shared types, codes and helpers for the clipped fill and sprite blit unit.
// ----------------------------------------------------------------------------
package cfsb_pkg;

    // field widths
    localparam int ACTION_W   = 3;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 9;
    localparam int COLOR_W    = 32;
    localparam int ROW_IDX_W  = 4;
    localparam int MASK_W     = 16;
    localparam int MASK_BIT_W = 4;
    localparam int IDX_W      = 2 * DIM_W;
    localparam int CFG_IDX_W  = 2;

    // stream packing
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = COLOR_W;
    localparam int M_TUSER_W = 1;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RECT     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ROW = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SPRITE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 9'd256;

    // one command as taken from the input stream
    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [COORD_W-1:0]   box_width;
        logic [COORD_W-1:0]   box_height;
        logic [COLOR_W-1:0]   paint_color;
        logic [ROW_IDX_W-1:0] mask_row_index;
        logic [MASK_W-1:0]    mask_row_bits;
    } cmd_t;

    // frame store access control
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic in_bounds;
    } fs_req_t;

    // span length clipped to the room left before the frame edge
    function automatic logic [DIM_W-1:0] clip_len(
        input logic [COORD_W-1:0] len,
        input logic [DIM_W-1:0]   room
    );
        logic [DIM_W-1:0] res;
        begin
            res = (len > COORD_W'(room)) ? room : DIM_W'(len);
            return res;
        end
    endfunction

endpackage

// ===== src/cfsb_frame_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsb_frame_store
// Frame pixel memory with one write and one registered read per cycle; the
// read data register doubles as the result output register.
// ----------------------------------------------------------------------------
module cfsb_frame_store #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cfsb_pkg::fs_req_t                    req,
    input  logic [AW-1:0]                        addr,
    input  logic [cfsb_pkg::COLOR_W-1:0]         wdata,
    output logic                                 out_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cfsb_pkg::M_TDATA_W-1:0]       m_tdata,   // pixel_color
    output logic [cfsb_pkg::M_TUSER_W-1:0]       m_tuser    // in_bounds
);
    import cfsb_pkg::*;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] q_reg;
    logic               inb_reg;
    logic               valid_reg;
    logic               valid_next;

    // memory port, read data held until the next read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (req.rd_en)
        begin
            q_reg   <= mem[addr];
            inb_reg <= req.in_bounds;
        end
    end

    // result slot occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (req.rd_en)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = inb_reg ? q_reg : '0;
    assign m_tuser  = inb_reg;

endmodule

// ===== src/cfsb_raster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsb_raster
// Command sequencer: clips boxes and sprites, walks pixels one per cycle bar
// mask fetches, holds the sprite mask memory and issues frame store accesses.
// ----------------------------------------------------------------------------
module cfsb_raster #(
    parameter int AW              = 16,
    parameter int SPRITE_MAX_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  cfsb_pkg::cmd_t                cmd,
    input  logic [cfsb_pkg::DIM_W-1:0]    eff_w,
    input  logic [cfsb_pkg::DIM_W-1:0]    eff_h,
    input  logic                          out_free,
    output cfsb_pkg::fs_req_t             req,
    output logic [AW-1:0]                 addr,
    output logic [cfsb_pkg::COLOR_W-1:0]  wdata
);
    import cfsb_pkg::*;

    localparam int MASK_ROWS = (SPRITE_MAX_SIZE < MASK_W) ? SPRITE_MAX_SIZE : MASK_W;
    localparam int MIW       = $clog2(MASK_ROWS);
    localparam int SZW       = $clog2(SPRITE_MAX_SIZE + 1);
    localparam int MRW       = $clog2(SPRITE_MAX_SIZE);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_MASK  = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [DIM_W-1:0]    px_reg, px_next;
    logic                inb_reg, inb_next;
    logic [IDX_W-1:0]    mul_reg, mul_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [DIM_W-1:0]    ncols_reg, ncols_next;
    logic [DIM_W-1:0]    nrows_reg, nrows_next;
    logic [DIM_W-1:0]    xo_reg, xo_next;
    logic [DIM_W-1:0]    yo_reg, yo_next;
    logic [MRW-1:0]      mrow_reg, mrow_next;

    logic [MASK_W-1:0]   mask_mem [MASK_ROWS];
    logic [MASK_W-1:0]   mask_q_reg;

    logic                accept;
    logic                x_in, y_in;
    logic [DIM_W-1:0]    room_x, room_y;
    logic [SZW-1:0]      sw_in, sh_in;
    logic [COORD_W-1:0]  span_w, span_h;
    logic [DIM_W-1:0]    ncols_in, nrows_in;
    logic                draw_empty;
    logic [DIM_W-1:0]    mul_a;
    logic                row_last, col_last;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    // clipping of the incoming command
    always_comb
    begin
        x_in   = cmd.pos_x < COORD_W'(eff_w);
        y_in   = cmd.pos_y < COORD_W'(eff_h);
        room_x = eff_w - DIM_W'(cmd.pos_x);
        room_y = eff_h - DIM_W'(cmd.pos_y);
        sw_in  = (int'(cmd.box_width) > SPRITE_MAX_SIZE) ?
                 SZW'(SPRITE_MAX_SIZE) : SZW'(cmd.box_width);
        sh_in  = (int'(cmd.box_height) > SPRITE_MAX_SIZE) ?
                 SZW'(SPRITE_MAX_SIZE) : SZW'(cmd.box_height);
        if (cmd.action == ACT_SPRITE)
        begin
            span_w = (int'(sw_in) > MASK_W) ? COORD_W'(MASK_W) : COORD_W'(sw_in);
            span_h = COORD_W'(sh_in);
        end
        else
        begin
            span_w = cmd.box_width;
            span_h = cmd.box_height;
        end
        ncols_in   = clip_len(span_w, room_x);
        nrows_in   = clip_len(span_h, room_y);
        draw_empty = !x_in || !y_in || (ncols_in == '0) || (nrows_in == '0);
        mul_a      = (cmd.action == ACT_CLEAR) ? eff_h : DIM_W'(cmd.pos_y);
    end

    assign col_last = (xo_reg == ncols_reg - DIM_W'(1));
    assign row_last = (yo_reg == nrows_reg - DIM_W'(1));

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        color_next  = color_reg;
        px_next     = px_reg;
        inb_next    = inb_reg;
        mul_next    = mul_reg;
        base_next   = base_reg;
        cnt_next    = cnt_reg;
        ncols_next  = ncols_reg;
        nrows_next  = nrows_reg;
        xo_next     = xo_reg;
        yo_next     = yo_reg;
        mrow_next   = mrow_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next = cmd.action;
                    color_next  = cmd.paint_color;
                    px_next     = DIM_W'(cmd.pos_x);
                    inb_next    = x_in && y_in;
                    mul_next    = IDX_W'(mul_a) * IDX_W'(eff_w);
                    ncols_next  = ncols_in;
                    nrows_next  = nrows_in;
                    mrow_next   = MRW'(sh_in - SZW'(1));
                    case (cmd.action)
                        ACT_CLEAR, ACT_READ:
                        begin
                            state_next = ST_SETUP;
                        end
                        ACT_RECT, ACT_SPRITE:
                        begin
                            if (!draw_empty)
                            begin
                                state_next = ST_SETUP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                base_next = mul_reg + IDX_W'(px_reg);
                cnt_next  = '0;
                xo_next   = '0;
                yo_next   = '0;
                case (action_reg)
                    ACT_CLEAR:  state_next = (mul_reg == '0) ? ST_IDLE : ST_CLEAR;
                    ACT_RECT:   state_next = ST_RUN;
                    ACT_SPRITE: state_next = ST_MASK;
                    ACT_READ:   state_next = ST_READ;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == mul_reg - IDX_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MASK:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (col_last)
                begin
                    xo_next = '0;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        yo_next   = yo_reg + DIM_W'(1);
                        base_next = base_reg + IDX_W'(eff_w);
                        mrow_next = mrow_reg - MRW'(1);
                        if (action_reg == ACT_SPRITE)
                        begin
                            state_next = ST_MASK;
                        end
                    end
                end
                else
                begin
                    xo_next = xo_reg + DIM_W'(1);
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // command payload and walk counters
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        color_reg  <= color_next;
        px_reg     <= px_next;
        inb_reg    <= inb_next;
        mul_reg    <= mul_next;
        base_reg   <= base_next;
        cnt_reg    <= cnt_next;
        ncols_reg  <= ncols_next;
        nrows_reg  <= nrows_next;
        xo_reg     <= xo_next;
        yo_reg     <= yo_next;
        mrow_reg   <= mrow_next;
    end

    // sprite mask memory, rows beyond its depth read as empty
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.action == ACT_LOAD_ROW) &&
            (int'(cmd.mask_row_index) < MASK_ROWS))
        begin
            mask_mem[cmd.mask_row_index[MIW-1:0]] <= cmd.mask_row_bits;
        end
        if (state_reg == ST_MASK)
        begin
            mask_q_reg <= (int'(mrow_reg) < MASK_ROWS) ? mask_mem[mrow_reg[MIW-1:0]] : '0;
        end
    end

    // frame store access
    always_comb
    begin
        req.wr_en     = (state_reg == ST_CLEAR) ||
                        ((state_reg == ST_RUN) &&
                         ((action_reg == ACT_RECT) || mask_q_reg[xo_reg[MASK_BIT_W-1:0]]));
        req.rd_en     = (state_reg == ST_READ) && out_free;
        req.in_bounds = inb_reg;
        addr          = (state_reg == ST_CLEAR) ? AW'(cnt_reg) :
                        AW'(base_reg + IDX_W'(xo_reg));
        wdata         = color_reg;
    end

endmodule

// ===== src/clipped_fill_and_sprite_blit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_fill_and_sprite_blit_unit
// 2D drawing engine over a stored frame of 32-bit pixels: clear, clipped
// rectangle fill, sprite mask load, flipped sprite draw and pixel read.
//
//  channel   direction  handshake                   contents
//  cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
//  s         in         s_tvalid / s_tready         command (tuser action)
//  m         out        m_tvalid / m_tready         pixel (tuser in_bounds)
//
//  clear fills the active frame, one pixel write per cycle
//  rect fill writes the clipped area; sprite draw fetches one mask row before
//  each clipped row; load row, empty draws and unknown actions leave the
//  engine idle
//  read waits for the result register to drain before it is issued
//  the frame memory has a single write port
//  no clearing pass after reset; a stall on m holds a read and what follows it
// ----------------------------------------------------------------------------
module clipped_fill_and_sprite_blit_unit #(
    parameter int FRAME_MAX_WIDTH  = 256,
    parameter int FRAME_MAX_HEIGHT = 256,
    parameter int SPRITE_MAX_SIZE  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cfsb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfsb_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, box_width, box_height, paint_color, mask_row_index,
    // mask_row_bits, zero fill
    input  logic [cfsb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [cfsb_pkg::S_TUSER_W-1:0]     s_tuser,   // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cfsb_pkg::M_TDATA_W-1:0]     m_tdata,   // pixel_color
    output logic [cfsb_pkg::M_TUSER_W-1:0]     m_tuser    // in_bounds
);
    import cfsb_pkg::*;

    localparam int DEPTH = FRAME_MAX_WIDTH * FRAME_MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam int POS_X_LSB = 0;
    localparam int POS_Y_LSB = POS_X_LSB + COORD_W;
    localparam int BOX_W_LSB = POS_Y_LSB + COORD_W;
    localparam int BOX_H_LSB = BOX_W_LSB + COORD_W;
    localparam int COLOR_LSB = BOX_H_LSB + COORD_W;
    localparam int ROW_LSB   = COLOR_LSB + COLOR_W;
    localparam int BITS_LSB  = ROW_LSB + ROW_IDX_W;

    logic [DIM_W-1:0] frame_width_reg, frame_width_next;
    logic [DIM_W-1:0] frame_height_reg, frame_height_next;
    logic [DIM_W-1:0] eff_w, eff_h;
    cmd_t             cmd;
    fs_req_t          req;
    logic [AW-1:0]    addr;
    logic [COLOR_W-1:0] wdata;
    logic             out_free;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_DIM_RESET;
            frame_height_reg <= FRAME_DIM_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // active frame size saturates at the stored frame size
    assign eff_w = (int'(frame_width_reg) > FRAME_MAX_WIDTH) ?
                   DIM_W'(FRAME_MAX_WIDTH) : frame_width_reg;
    assign eff_h = (int'(frame_height_reg) > FRAME_MAX_HEIGHT) ?
                   DIM_W'(FRAME_MAX_HEIGHT) : frame_height_reg;

    // command unpacking
    always_comb
    begin
        cmd.action         = s_tuser;
        cmd.pos_x          = s_tdata[POS_X_LSB +: COORD_W];
        cmd.pos_y          = s_tdata[POS_Y_LSB +: COORD_W];
        cmd.box_width      = s_tdata[BOX_W_LSB +: COORD_W];
        cmd.box_height     = s_tdata[BOX_H_LSB +: COORD_W];
        cmd.paint_color    = s_tdata[COLOR_LSB +: COLOR_W];
        cmd.mask_row_index = s_tdata[ROW_LSB +: ROW_IDX_W];
        cmd.mask_row_bits  = s_tdata[BITS_LSB +: MASK_W];
    end

    cfsb_raster #(
        .AW              (AW),
        .SPRITE_MAX_SIZE (SPRITE_MAX_SIZE)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .out_free  (out_free),
        .req       (req),
        .addr      (addr),
        .wdata     (wdata)
    );

    cfsb_frame_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .addr     (addr),
        .wdata    (wdata),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a pixel write and a pixel read never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("frame store read and write in one cycle");

    // a read is issued only into a free result slot
    assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |-> (!m_tvalid || m_tready))
        else $error("read overwrote a pending result");

    // an issued read shows up as a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |=> m_tvalid)
        else $error("read result lost");

    // no new command is taken while pixels are being written
    assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> !s_tready)
        else $error("command accepted during a draw");

endmodule

// ===== verif/clipped_fill_and_sprite_blit_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_fill_and_sprite_blit_unit_tb
// Self-checking bench for the blit unit. Commands stream in as bursts with
// random gaps while the pixel port stalls on its own pattern. The bench keeps
// a mirror of the frame and the sprite mask rows, predicts every pixel read
// and compares each returned transaction in order. Between phases the engine
// is drained and the frame size is moved through empty, single pixel,
// saturated and random settings.
// ----------------------------------------------------------------------------
module clipped_fill_and_sprite_blit_unit_tb;
    import cfsb_pkg::*;

    localparam int          FRAME_MAX     = 256;
    localparam int          SPRITE_MAX    = 16;
    localparam int          CMD_BITS      = 92;
    localparam int          NUM_PHASES    = 12;
    localparam int          ITEMS_TOTAL   = 1400;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 5_000_000;

    // unmapped register index, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // action codes the engine ignores
    localparam logic [ACTION_W-1:0] ACT_UNDEF_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_LAST  = 3'd7;

    typedef enum int unsigned {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_TOGGLE,
        RDY_HOLD
    } ready_mode_e;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               in_bounds;
    } pixel_t;

    // frame and sprite mirror plus the queue of pixel reads in flight
    class pixel_scoreboard;
        bit [COLOR_W-1:0] frame_mem [0:FRAME_MAX*FRAME_MAX-1];
        bit [MASK_W-1:0]  sprite_rows [0:SPRITE_MAX-1];
        int unsigned      reg_width;
        int unsigned      reg_height;
        pixel_t           pending_reads [$];
        int unsigned      errors;
        int unsigned      reads_checked;

        function new();
            reg_width     = 256;
            reg_height    = 256;
            errors        = 0;
            reads_checked = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DIM_W-1:0] val);
            if (idx == REG_FRAME_WIDTH)
                reg_width = val;
            else if (idx == REG_FRAME_HEIGHT)
                reg_height = val;
        endfunction

        // update the mirror for one accepted command, queue a read result
        function void apply_command(input cmd_t c);
            int unsigned w, h, px, py, bw, bh, sw, sh, xi, yi, x, y, i;
            pixel_t      res;
            w  = (reg_width > FRAME_MAX) ? FRAME_MAX : reg_width;
            h  = (reg_height > FRAME_MAX) ? FRAME_MAX : reg_height;
            px = c.pos_x;
            py = c.pos_y;
            bw = c.box_width;
            bh = c.box_height;
            case (c.action)
                ACT_CLEAR:
                begin
                    for (i = 0; i < w * h; i++)
                        frame_mem[i] = c.paint_color;
                end
                ACT_RECT:
                begin
                    for (yi = py; yi < py + bh && yi < h; yi++)
                        for (xi = px; xi < px + bw && xi < w; xi++)
                            frame_mem[yi * w + xi] = c.paint_color;
                end
                ACT_LOAD_ROW:
                begin
                    sprite_rows[c.mask_row_index] = c.mask_row_bits;
                end
                ACT_SPRITE:
                begin
                    sw = (bw > SPRITE_MAX) ? SPRITE_MAX : bw;
                    sh = (bh > SPRITE_MAX) ? SPRITE_MAX : bh;
                    // mask row r lands on the mirrored row of the box
                    for (yi = 0; yi < sh; yi++)
                        for (xi = 0; xi < sw; xi++)
                            if (sprite_rows[yi][xi])
                            begin
                                x = px + xi;
                                y = py + sh - 1 - yi;
                                if (x < w && y < h)
                                    frame_mem[y * w + x] = c.paint_color;
                            end
                end
                ACT_READ:
                begin
                    res.in_bounds = (px < w) && (py < h);
                    res.color     = res.in_bounds ? frame_mem[py * w + px] : '0;
                    pending_reads.push_back(res);
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare one returned pixel transaction with the oldest read
        function void check_pixel(input logic [COLOR_W-1:0] color, input logic inb);
            pixel_t want;
            if (pending_reads.size() == 0)
            begin
                errors++;
                $error("unexpected pixel transaction: pixel_color %h in_bounds %b",
                       color, inb);
                return;
            end
            want = pending_reads.pop_front();
            reads_checked++;
            if (color !== want.color)
            begin
                errors++;
                $error("pixel_color mismatch: expected %h, actual %h", want.color, color);
            end
            if (inb !== want.in_bounds)
            begin
                errors++;
                $error("in_bounds mismatch: expected %b, actual %b", want.in_bounds, inb);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    pixel_scoreboard sb = new();
    int unsigned     burst_left = 0;
    int unsigned     commands_sent = 0;
    int unsigned     cycle_count = 0;

    clipped_fill_and_sprite_blit_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL clipped_fill_and_sprite_blit_unit");
            $finish;
        end
    end

    // pixel port monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_pixel(m_tdata, m_tuser[0]);
    end

    // pixel port backpressure, switching between stall patterns
    initial
    begin : ready_pattern
        ready_mode_e mode;
        int unsigned span;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = ready_mode_e'($urandom_range(0, 4));
            span = (mode == RDY_HOLD) ? $urandom_range(1, 60) : $urandom_range(16, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                    RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    RDY_TOGGLE: m_tready <= ~m_tready;
                    default:    m_tready <= 1'b0;
                endcase
            end
        end
    end

    function automatic cmd_t draw_cmd(input logic [ACTION_W-1:0] act,
                                      input int unsigned x, input int unsigned y,
                                      input int unsigned bw, input int unsigned bh,
                                      input logic [COLOR_W-1:0] color);
        cmd_t c;
        c.action         = act;
        c.pos_x          = COORD_W'(x);
        c.pos_y          = COORD_W'(y);
        c.box_width      = COORD_W'(bw);
        c.box_height     = COORD_W'(bh);
        c.paint_color    = color;
        c.mask_row_index = ROW_IDX_W'($urandom_range(0, 15));
        c.mask_row_bits  = MASK_W'($urandom_range(0, 65535));
        return c;
    endfunction

    // one command transaction, then a gap when the current burst runs out
    task automatic send_command(input cmd_t c);
        int unsigned gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= c.action;
        s_tdata  <= {{(S_TDATA_W-CMD_BITS){1'b0}}, c.mask_row_bits, c.mask_row_index,
                     c.paint_color, c.box_height, c.box_width, c.pos_y, c.pos_x};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.apply_command(c);
        commands_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // a trailing read returns only after every earlier draw has finished
    task automatic drain_engine();
        send_command(draw_cmd(ACT_READ, 0, 0, 0, 0, '0));
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        cmd_t          c;
        int unsigned   w, h, ew, eh, phase, done, pick, r;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: full frame after reset, every mask row loaded first
        send_command(draw_cmd(ACT_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF));
        for (r = 0; r < SPRITE_MAX; r++)
        begin
            c = draw_cmd(ACT_LOAD_ROW, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         0, 0, $urandom);
            c.mask_row_index = ROW_IDX_W'(r);
            if (r == 0)
                c.mask_row_bits = 16'hFFFF;
            else if (r == 1)
                c.mask_row_bits = 16'h0001;
            else if (r == SPRITE_MAX - 1)
                c.mask_row_bits = 16'h8000;
            send_command(c);
        end
        // clipped at both edges, zero width, zero height
        send_command(draw_cmd(ACT_RECT, 250, 250, 1023, 1023, 32'h0000_0000));
        send_command(draw_cmd(ACT_RECT, 0, 0, 0, 5, 32'h1111_1111));
        send_command(draw_cmd(ACT_RECT, 10, 10, 5, 0, 32'h2222_2222));
        // oversized sprite clamped and clipped, full sprite, tiny sprite
        send_command(draw_cmd(ACT_SPRITE, 248, 248, 1023, 1023, 32'hA5A5_5A5A));
        send_command(draw_cmd(ACT_SPRITE, 0, 0, 16, 16, 32'h1234_5678));
        send_command(draw_cmd(ACT_SPRITE, 20, 20, 3, 2, 32'hCAFE_F00D));
        // corner, just outside, far outside, flipped sprite rows
        send_command(draw_cmd(ACT_READ, 255, 255, 0, 0, '0));
        send_command(draw_cmd(ACT_READ, 256, 0, 0, 0, '0));
        send_command(draw_cmd(ACT_READ, 1023, 1023, 0, 0, '0));
        send_command(draw_cmd(ACT_READ, 0, 0, 0, 0, '0));
        send_command(draw_cmd(ACT_READ, 0, 15, 0, 0, '0));
        for (r = ACT_UNDEF_FIRST; r <= ACT_UNDEF_LAST; r++)
            send_command(draw_cmd(ACTION_W'(r), 1, 1, 4, 4, $urandom));
        drain_engine();
        write_register(REG_SPARE, '1);

        // frame size sweep, each phase opens with a clear
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       begin w = 1;   h = 1;   end   // single pixel
                1:       begin w = 0;   h = 5;   end   // empty, zero width
                2:       begin w = 511; h = 1;   end   // width saturates
                3:       begin w = 3;   h = 256; end
                4:       begin w = 256; h = 2;   end
                5:       begin w = 9;   h = 0;   end   // empty, zero height
                6:       begin w = 2;   h = 400; end   // height saturates
                default:
                begin
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 40);
                end
            endcase
            ew = (w > FRAME_MAX) ? FRAME_MAX : w;
            eh = (h > FRAME_MAX) ? FRAME_MAX : h;
            write_register(REG_FRAME_WIDTH, DIM_W'(w));
            write_register(REG_FRAME_HEIGHT, DIM_W'(h));
            send_command(draw_cmd(ACT_CLEAR, 0, 0, 0, 0, $urandom));

            done = 0;
            while (done < ITEMS_TOTAL / NUM_PHASES)
            begin
                c = draw_cmd(ACT_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
                pick = $urandom_range(0, 99);
                if (pick < 34)
                begin
                    // mostly inside or just past the frame, some anywhere
                    if ($urandom_range(0, 3) != 0)
                    begin
                        c.pos_x = COORD_W'($urandom_range(0, ew));
                        c.pos_y = COORD_W'($urandom_range(0, eh));
                    end
                end
                else if (pick < 56)
                begin
                    c.action = ACT_RECT;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        c.pos_x      = COORD_W'($urandom_range(0, ew + 2));
                        c.pos_y      = COORD_W'($urandom_range(0, eh + 2));
                        c.box_width  = COORD_W'($urandom_range(0, 12));
                        c.box_height = COORD_W'($urandom_range(0, 12));
                    end
                end
                else if (pick < 78)
                begin
                    c.action = ACT_SPRITE;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        c.pos_x      = COORD_W'($urandom_range(0, ew + 2));
                        c.pos_y      = COORD_W'($urandom_range(0, eh + 2));
                        c.box_width  = COORD_W'($urandom_range(0, SPRITE_MAX + 2));
                        c.box_height = COORD_W'($urandom_range(0, SPRITE_MAX + 2));
                    end
                end
                else if (pick < 88)
                    c.action = ACT_LOAD_ROW;
                else if (pick < 92)
                    c.action = ACT_CLEAR;
                else
                    c.action = ACTION_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
                send_command(c);
                done++;
            end
            drain_engine();
        end

        $display("sent %0d commands across %0d frame size phases, %0d pixel reads checked",
                 commands_sent, NUM_PHASES, sb.reads_checked);
        $display("sizes swept: empty, single pixel, saturated, tall, wide and random; %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending_reads.size() == 0)
            $display("PASS clipped_fill_and_sprite_blit_unit");
        else
            $display("FAIL clipped_fill_and_sprite_blit_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cfsb_pkg.sv
src/cfsb_frame_store.sv
src/cfsb_raster.sv
src/clipped_fill_and_sprite_blit_unit.sv
verif/clipped_fill_and_sprite_blit_unit_tb.sv
